// ===== rtl/scan_telegram_deframer_core_macros.svh =====
// Assertion macros for the scan telegram deframer.
`ifndef SCAN_TELEGRAM_DEFRAMER_CORE_MACROS_SVH
`define SCAN_TELEGRAM_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define STDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/stdf_pkg.sv =====
// Types and constants shared by the scan telegram deframer modules.
package stdf_pkg;

  localparam logic [7:0] START_BYTE      = 8'h02;
  localparam logic [7:0] COUNT_HIGH_MASK = 8'h1f;
  localparam logic [7:0] CLASS_MASK      = 8'h07;
  localparam logic [7:0] PLAUS_MASK      = 8'hc0;

  localparam logic [1:0] KIND_READING = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  localparam logic [1:0] CLASS_OK    = 2'd0;
  localparam logic [1:0] CLASS_ERROR = 2'd1;
  localparam logic [1:0] CLASS_FATAL = 2'd2;

  typedef enum logic [10:0] {
    PH_WAIT   = 11'b000_0000_0001,
    PH_ADDR   = 11'b000_0000_0010,
    PH_LEN_LO = 11'b000_0000_0100,
    PH_LEN_HI = 11'b000_0000_1000,
    PH_CMD    = 11'b000_0001_0000,
    PH_CNT_LO = 11'b000_0010_0000,
    PH_CNT_HI = 11'b000_0100_0000,
    PH_DATA   = 11'b000_1000_0000,
    PH_STATUS = 11'b001_0000_0000,
    PH_CRC_LO = 11'b010_0000_0000,
    PH_CRC_HI = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [12:0] readings_left;
    logic [7:0]  count_low;
    logic [7:0]  held_low_byte;
    logic        odd_byte;
    logic [7:0]  held_status;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] reading;
    logic [7:0]  status_byte;
    logic [1:0]  status_class;
    logic        plausible;
    logic        last;
  } result_t;

endpackage

// ===== rtl/stdf_step.sv =====
// Next-state and result logic for one received byte.
module stdf_step (
  input  stdf_pkg::state_t  st,
  input  logic [7:0]        rx_byte,
  output stdf_pkg::state_t  st_next,
  output logic              res_valid,
  output stdf_pkg::result_t res
);
  import stdf_pkg::*;

  logic [2:0]  low3;
  logic [12:0] count;
  logic [12:0] left_dec;

  assign low3     = st.held_status[2:0] & CLASS_MASK[2:0];
  assign count    = {rx_byte[4:0] & COUNT_HIGH_MASK[4:0], st.count_low};
  assign left_dec = st.readings_left - 13'd1;

  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    case (st.phase)
      PH_ADDR:   st_next.phase = PH_LEN_LO;
      PH_LEN_LO: st_next.phase = PH_LEN_HI;
      PH_LEN_HI: st_next.phase = PH_CMD;
      PH_CMD:    st_next.phase = PH_CNT_LO;
      PH_CNT_LO: begin
        st_next.count_low = rx_byte;
        st_next.phase     = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        st_next.readings_left = count;
        st_next.odd_byte      = 1'b0;
        st_next.phase         = (count == 13'd0) ? PH_STATUS : PH_DATA;
      end
      PH_DATA: begin
        if (!st.odd_byte) begin
          st_next.held_low_byte = rx_byte;
          st_next.odd_byte      = 1'b1;
        end else begin
          st_next.odd_byte      = 1'b0;
          res_valid             = 1'b1;
          res.kind              = KIND_READING;
          res.reading           = {rx_byte, st.held_low_byte};
          st_next.readings_left = left_dec;
          if (left_dec == 13'd0) begin
            st_next.phase = PH_STATUS;
          end
        end
      end
      PH_STATUS: begin
        st_next.held_status = rx_byte;
        st_next.phase       = PH_CRC_LO;
      end
      PH_CRC_LO: st_next.phase = PH_CRC_HI;
      PH_CRC_HI: begin
        res_valid        = 1'b1;
        res.kind         = KIND_END;
        res.status_byte  = st.held_status;
        res.status_class = (low3 <= 3'd2) ? CLASS_OK :
                           ((low3 == 3'd3) ? CLASS_ERROR : CLASS_FATAL);
        res.plausible    = ((st.held_status & PLAUS_MASK) == 8'h00);
        res.last         = 1'b1;
        st_next.phase    = PH_WAIT;
      end
      default: begin
        if (rx_byte == START_BYTE) begin
          st_next.phase = PH_ADDR;
        end else begin
          st_next.phase = PH_WAIT;
          res_valid     = 1'b1;
          res.kind      = KIND_BAD;
        end
      end
    endcase
  end

endmodule

// ===== rtl/stdf_oq.sv =====
// Two-word output register with skid stage.
module stdf_oq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stdf_pkg::result_t push_word,
  input  logic              pop_ready,
  output logic              out_valid,
  output stdf_pkg::result_t out_word,
  output logic              full
);
  import stdf_pkg::*;

  logic    skid_valid;
  result_t skid_word;
  logic    take;

  assign take = out_valid & pop_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_word <= skid_valid ? skid_word : push_word;
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

// ===== rtl/scan_telegram_deframer_core.sv =====
// Scan telegram deframer top level.
// Takes one received scanner byte per cycle while not stalled and splits
// measurement telegrams into readings and a closing status word. The input
// stalls only while both the output register and its skid stage hold a word
// that the sink has not yet taken. A reading is pushed into the output
// register, or into its skid stage while that register is held, when its high
// byte is taken; so is the frame-end word on the last CRC byte and a bad-start
// word on a dropped byte. tlast marks the frame-end word, tuser the word kind.
module scan_telegram_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] reading, [23:16] status_byte,
                                     // [25:24] status_class, [26] plausible
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast
);
  import stdf_pkg::*;

`include "scan_telegram_deframer_core_macros.svh"

  state_t  st;
  state_t  st_next;
  logic    res_valid;
  result_t res;
  result_t out_word;
  logic    q_full;
  logic    accept;

  assign s_axis_tready = ~q_full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  stdf_step u_step (
    .st        (st),
    .rx_byte   (s_axis_tdata),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  stdf_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & res_valid),
    .push_word (res),
    .pop_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_word  (out_word),
    .full      (q_full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_WAIT, readings_left: '0, count_low: '0, held_low_byte: '0,
              odd_byte: 1'b0, held_status: '0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  assign m_axis_tdata = {5'd0, out_word.plausible, out_word.status_class,
                         out_word.status_byte, out_word.reading};
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;

  `STDF_ASSERT_NOW(a_stall_only_full, !s_axis_tready, m_axis_tvalid)
  `STDF_ASSERT_NOW(a_data_has_left, st.phase == PH_DATA, st.readings_left != 13'd0)
  `STDF_ASSERT_NOW(a_end_from_crc, accept && res_valid && res.last, st.phase == PH_CRC_HI)
  `STDF_ASSERT_NEXT(a_crc_to_wait, accept && st.phase == PH_CRC_HI, st.phase == PH_WAIT)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the scan telegram deframer core.
`timescale 1ns / 1ps

module tb_top;
  import stdf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] rx_byte;
    bit         typed;
    bit         has_word;
    result_t    word;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  result_t expected_words[$];
  row_t    directed_rows[$];
  int      fail_count = 0;
  int      bytes_sent = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_reqs = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      stall_cycles = 0;

  // predictor state
  phase_t      frame_phase = PH_WAIT;
  logic [12:0] readings_left = '0;
  logic [7:0]  count_lo = '0;
  logic [7:0]  low_byte = '0;
  logic        odd_byte = 1'b0;
  logic [7:0]  status_hold = '0;

  scan_telegram_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  function automatic bit predict_byte(input logic [7:0] b, output result_t w);
    logic [7:0] low3;
    bit         has;
    has = 1'b0;
    w = '0;
    case (frame_phase)
      PH_ADDR:   frame_phase = PH_LEN_LO;
      PH_LEN_LO: frame_phase = PH_LEN_HI;
      PH_LEN_HI: frame_phase = PH_CMD;
      PH_CMD:    frame_phase = PH_CNT_LO;
      PH_CNT_LO: begin
        count_lo = b;
        frame_phase = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        readings_left = {b[4:0] & COUNT_HIGH_MASK[4:0], count_lo};
        odd_byte = 1'b0;
        frame_phase = (readings_left == 13'd0) ? PH_STATUS : PH_DATA;
      end
      PH_DATA: begin
        if (!odd_byte) begin
          low_byte = b;
          odd_byte = 1'b1;
        end else begin
          odd_byte = 1'b0;
          w.kind = KIND_READING;
          w.reading = {b, low_byte};
          has = 1'b1;
          readings_left = readings_left - 13'd1;
          if (readings_left == 13'd0) frame_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        status_hold = b;
        frame_phase = PH_CRC_LO;
      end
      PH_CRC_LO: frame_phase = PH_CRC_HI;
      PH_CRC_HI: begin
        low3 = status_hold & CLASS_MASK;
        w.kind = KIND_END;
        w.status_byte = status_hold;
        w.status_class = (low3 <= 8'd2) ? CLASS_OK : ((low3 == 8'd3) ? CLASS_ERROR : CLASS_FATAL);
        w.plausible = ((status_hold & PLAUS_MASK) == 8'h00);
        w.last = 1'b1;
        has = 1'b1;
        frame_phase = PH_WAIT;
      end
      default: begin
        if (b == START_BYTE) begin
          frame_phase = PH_ADDR;
        end else begin
          frame_phase = PH_WAIT;
          w.kind = KIND_BAD;
          has = 1'b1;
        end
      end
    endcase
    return has;
  endfunction

  function automatic void row_free(input logic [7:0] b);
    directed_rows.push_back('{b, 1'b0, 1'b0, result_t'('0)});
  endfunction

  function automatic void row_typed(input logic [7:0] b, input bit has, input result_t w);
    directed_rows.push_back('{b, 1'b1, has, w});
  endfunction

  function automatic logic [7:0] frame_byte();
    return ($urandom_range(3, 0) == 0) ? START_BYTE : 8'($urandom_range(255, 0));
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input bit has_t,
                           input result_t typed_word);
    result_t w;
    bit      has;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    has = predict_byte(b, w);
    if (typed) begin
      if (has_t) expected_words.push_back(typed_word);
    end else if (has) begin
      expected_words.push_back(w);
    end
  endtask

  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic run_frames(input int quota);
    logic [7:0] frame_q[$];
    logic [7:0] lo;
    logic [7:0] hi;
    int         stop_at;
    int         pick;
    int         n;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      frame_q.delete();
      pick = $urandom_range(99, 0);
      if (pick < 12) begin
        n = $urandom_range(3, 1);
        repeat (n) frame_q.push_back(8'($urandom_range(255, 0)));
      end else begin
        lo = ($urandom_range(24, 0) == 0) ? 8'($urandom_range(255, 0))
                                          : 8'($urandom_range(6, 0));
        hi = {3'($urandom_range(7, 0)), 4'b0000, ($urandom_range(39, 0) == 0)};
        frame_q.push_back(START_BYTE);
        repeat (4) frame_q.push_back(frame_byte());
        frame_q.push_back(lo);
        frame_q.push_back(hi);
        repeat (2 * int'({hi[4:0], lo})) frame_q.push_back(frame_byte());
        frame_q.push_back(8'($urandom_range(255, 0)));
        repeat (2) frame_q.push_back(frame_byte());
        // cut short a few frames
        if (pick < 20) begin
          n = $urandom_range(frame_q.size() - 1, 1);
          while (frame_q.size() > n) void'(frame_q.pop_back());
        end
      end
      foreach (frame_q[i]) begin
        if (bytes_sent < stop_at) send_byte(frame_q[i], 1'b0, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[15:0] !== want.reading) begin
          $error("reading: expected %h, actual %h", want.reading, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tdata[23:16] !== want.status_byte) begin
          $error("status_byte: expected %h, actual %h", want.status_byte,
                 m_axis_tdata[23:16]);
          fail_count++;
        end
        if (m_axis_tdata[25:24] !== want.status_class) begin
          $error("status_class: expected %0d, actual %0d", want.status_class,
                 m_axis_tdata[25:24]);
          fail_count++;
        end
        if (m_axis_tdata[26] !== want.plausible) begin
          $error("plausible: expected %0d, actual %0d", want.plausible, m_axis_tdata[26]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_typed(8'hff, 1'b1, {KIND_BAD, 16'h0000, 8'h00, CLASS_OK, 1'b0, 1'b0});
    // zero count frame, start byte as command, masked count high
    row_typed(START_BYTE, 1'b0, '0);
    row_typed(8'hff, 1'b0, '0);
    row_typed(8'h00, 1'b0, '0);
    row_typed(8'hff, 1'b0, '0);
    row_typed(START_BYTE, 1'b0, '0);
    row_typed(8'h00, 1'b0, '0);
    row_typed(8'he0, 1'b0, '0);
    row_typed(8'h03, 1'b0, '0);
    row_typed(8'hff, 1'b0, '0);
    row_typed(8'h00, 1'b1, {KIND_END, 16'h0000, 8'h03, CLASS_ERROR, 1'b1, 1'b1});
    // two readings at the extremes, fatal implausible status
    row_free(START_BYTE);
    repeat (4) row_free(8'h00);
    row_free(8'h02);
    row_free(8'h00);
    row_free(8'h00);
    row_typed(8'h00, 1'b1, {KIND_READING, 16'h0000, 8'h00, CLASS_OK, 1'b0, 1'b0});
    row_free(8'hff);
    row_typed(8'hff, 1'b1, {KIND_READING, 16'hffff, 8'h00, CLASS_OK, 1'b0, 1'b0});
    row_free(8'hff);
    row_free(START_BYTE);
    row_typed(START_BYTE, 1'b1, {KIND_END, 16'h0000, 8'hff, CLASS_FATAL, 1'b0, 1'b1});

    tx_idle_pct = 12;
    rx_idle_pct <= 85;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                directed_rows[i].has_word, directed_rows[i].word);
    end
    run_frames(320);

    drain_words();
    tx_idle_pct = 85;
    rx_idle_pct <= 12;
    run_frames(320);

    drain_words();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    // stall the sink while bytes keep coming
    hold_reqs <= hold_reqs + 1;
    run_frames(310);

    drain_words();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/stdf_pkg.sv
rtl/stdf_step.sv
rtl/stdf_oq.sv
rtl/scan_telegram_deframer_core.sv
verif/tb_top.sv
